// ===== hdl/saw_pkg.sv =====
package saw_pkg;

   // Packet store geometry.
   localparam int BUFFER_DEPTH = 512;
   localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
   localparam int LEN_W        = $clog2(BUFFER_DEPTH + 1);

   // Field widths.
   localparam int MODE_W    = 2;
   localparam int BYTE_W    = 8;
   localparam int LOAD_IDX_W = 9;
   localparam int PKT_LEN_W = 10;
   localparam int TIMER_W   = 16;
   localparam int EVENT_W   = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // Item modes.
   localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_START   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SERVICE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_TICK    = 2'd3;

   // Result events.
   localparam logic [EVENT_W-1:0] EV_NONE    = 2'd0;
   localparam logic [EVENT_W-1:0] EV_ACK     = 2'd1;
   localparam logic [EVENT_W-1:0] EV_TIMEOUT = 2'd2;
   localparam logic [EVENT_W-1:0] EV_RESEND  = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PACKET_LEN    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLY_TIMEOUT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_BYTE      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBUG_MODE    = 2'd3;

   // Reset values of the registers.
   localparam logic [PKT_LEN_W-1:0] PACKET_LEN_RST    = 10'd1;
   localparam logic [TIMER_W-1:0]   REPLY_TIMEOUT_RST = 16'd1000;
   localparam logic [BYTE_W-1:0]    ACK_BYTE_RST      = 8'd6;

   // Status of the modulo unit as seen by the top level.
   typedef struct packed {
      logic             busy;
      logic [LEN_W-1:0] rem;
   } mod_status_type;

   // Packet length as used by the sender: zero acts as one, and a length
   // beyond the store acts as the store depth.
   function automatic logic [LEN_W-1:0] effective_len(input logic [PKT_LEN_W-1:0] n);
      logic [LEN_W-1:0] r;
      if (n == '0) begin
         r = LEN_W'(1);
      end else if (int'(n) > BUFFER_DEPTH) begin
         r = LEN_W'(BUFFER_DEPTH);
      end else begin
         r = LEN_W'(n);
      end
      return r;
   endfunction

endpackage

// ===== hdl/saw_mod.sv =====
// Restoring modulo, one quotient bit per cycle. Started by a pulse; the
// divisor must hold steady until busy drops.
module saw_mod (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [saw_pkg::LEN_W-1:0] dividend,
   input  logic [saw_pkg::LEN_W-1:0] divisor,
   output saw_pkg::mod_status_type   status
);

   localparam int CNT_W = $clog2(saw_pkg::LEN_W + 1);

   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [saw_pkg::LEN_W-1:0] dvd_ff, dvd_in;
   logic [saw_pkg::LEN_W-1:0] rem_ff, rem_in;
   logic [saw_pkg::LEN_W:0]   trial;

   always_comb begin
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      trial  = {rem_ff, dvd_ff[saw_pkg::LEN_W-1]};
      if (start) begin
         cnt_in = CNT_W'(saw_pkg::LEN_W);
         dvd_in = dividend;
         rem_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_W'(1);
         dvd_in = {dvd_ff[saw_pkg::LEN_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = saw_pkg::LEN_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[saw_pkg::LEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign status.busy = (cnt_ff != '0);
   assign status.rem  = rem_ff;

endmodule

// ===== hdl/stop_and_wait_packet_sender_top.sv =====
// Channel  | Ports                                   | Direction | Beat taken when
// ---------+-----------------------------------------+-----------+-------------------------
// request  | req_valid/req_ready, req_mode..rx_byte  | in        | req_valid && req_ready
// response | rsp_valid/rsp_ready, rsp_send_valid..   | out       | rsp_valid && rsp_ready
// config   | csr_write_en, csr_index, csr_wdata      | in        | csr_write_en
//
// One request beat gives one response beat, by way of the input and response registers.
// A new request beat can be taken every cycle while the response side does not stall;
// the response register and the input register let both sides stall independently.
// Writing packet_len starts a modulo unit that holds req_ready low until it
// has worked through every bit of the length.
// Reset is synchronous and clears all control state; the packet store is
// not cleared and reads of unwritten entries are undefined.
module stop_and_wait_packet_sender_top (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [saw_pkg::MODE_W-1:0]     req_mode,
   input  logic [saw_pkg::LOAD_IDX_W-1:0] req_load_index,
   input  logic [saw_pkg::BYTE_W-1:0]     req_load_byte,
   input  logic                           req_tx_ready,
   input  logic                           req_rx_present,
   input  logic [saw_pkg::BYTE_W-1:0]     req_rx_byte,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_send_valid,
   output logic [saw_pkg::BYTE_W-1:0]     rsp_send_byte,
   output logic [saw_pkg::EVENT_W-1:0]    rsp_event_res,
   output logic                           rsp_busy_res,
   output logic                           rsp_awaiting_reply,

   input  logic                           csr_write_en,
   input  logic [saw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [saw_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W  = saw_pkg::ADDR_W;
   localparam int LEN_W   = saw_pkg::LEN_W;
   localparam int BYTE_W  = saw_pkg::BYTE_W;
   localparam int TIMER_W = saw_pkg::TIMER_W;

   // Configuration registers.
   logic [saw_pkg::PKT_LEN_W-1:0] packet_len_ff;
   logic [TIMER_W-1:0]            reply_timeout_ff;
   logic [BYTE_W-1:0]             ack_byte_ff;
   logic                          debug_mode_ff;

   // Sender state.
   logic [ADDR_W-1:0]  send_index_ff, send_index_in;
   logic               busy_ff, busy_in;
   logic               wait_ff, wait_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;

   // Input register: the beat being worked on.
   logic                           in_valid_ff;
   logic [saw_pkg::MODE_W-1:0]     in_mode_ff;
   logic [saw_pkg::LOAD_IDX_W-1:0] in_load_index_ff;
   logic [BYTE_W-1:0]              in_load_byte_ff;
   logic                           in_tx_ready_ff;
   logic                           in_rx_present_ff;
   logic [BYTE_W-1:0]              in_rx_byte_ff;

   // Packet store, a separate copy of byte 0, and the prefetched byte.
   logic [BYTE_W-1:0] store_mem [BUFFER_DEPTH_LOCAL];
   logic [BYTE_W-1:0] byte0_ff;
   logic [BYTE_W-1:0] rd_data_ff;
   logic              fwd_hit_ff;
   logic [BYTE_W-1:0] fwd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;
   logic              wr_en;
   logic [BYTE_W-1:0] fetched_byte;

   // Response register.
   logic                        rsp_valid_ff;
   logic                        rsp_send_valid_ff, rsp_send_valid_in;
   logic [BYTE_W-1:0]           rsp_send_byte_ff, rsp_send_byte_in;
   logic [saw_pkg::EVENT_W-1:0] rsp_event_ff, rsp_event_in;

   // Handshake and helpers.
   logic                    advance;
   logic                    req_take;
   logic [LEN_W-1:0]        eff_len;
   logic [LEN_W-1:0]        next_idx;
   logic                    over_len;
   logic                    len_write;
   saw_pkg::mod_status_type mod_status;

   localparam int BUFFER_DEPTH_LOCAL = saw_pkg::BUFFER_DEPTH;

   // The working beat retires when the response register is free or drains.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (!in_valid_ff || advance) && !mod_status.busy;
   assign req_take  = req_valid && req_ready;
   assign len_write = csr_write_en && (csr_index == saw_pkg::CSR_PACKET_LEN);

   assign eff_len  = saw_pkg::effective_len(packet_len_ff);
   assign next_idx = LEN_W'(send_index_ff) + LEN_W'(1);
   // The index can only run past the length after packet_len was rewritten
   // mid-packet; the modulo unit has then already reduced it.
   assign over_len = (next_idx > eff_len);

   saw_mod u_mod (
      .clock    (clock),
      .reset    (reset),
      .start    (len_write),
      .dividend (next_idx),
      .divisor  (eff_len),
      .status   (mod_status)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         packet_len_ff    <= saw_pkg::PACKET_LEN_RST;
         reply_timeout_ff <= saw_pkg::REPLY_TIMEOUT_RST;
         ack_byte_ff      <= saw_pkg::ACK_BYTE_RST;
         debug_mode_ff    <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            saw_pkg::CSR_PACKET_LEN:    packet_len_ff    <= csr_wdata[saw_pkg::PKT_LEN_W-1:0];
            saw_pkg::CSR_REPLY_TIMEOUT: reply_timeout_ff <= csr_wdata[TIMER_W-1:0];
            saw_pkg::CSR_ACK_BYTE:      ack_byte_ff      <= csr_wdata[BYTE_W-1:0];
            saw_pkg::CSR_DEBUG_MODE:    debug_mode_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // The forwarded byte covers a load that retires on the same edge at which
   // the following beat reads the store.
   assign fetched_byte = fwd_hit_ff ? fwd_data_ff : rd_data_ff;

   // Sender logic for the working beat.
   always_comb begin
      logic             rx;
      logic [LEN_W-1:0] wrapped;
      send_index_in     = send_index_ff;
      busy_in           = busy_ff;
      wait_in           = wait_ff;
      timer_in          = timer_ff;
      rsp_send_valid_in = 1'b0;
      rsp_send_byte_in  = '0;
      rsp_event_in      = saw_pkg::EV_NONE;
      rx                = in_rx_present_ff;
      wrapped           = '0;
      case (in_mode_ff)
         saw_pkg::MODE_START: begin
            if (!busy_ff) begin
               send_index_in     = '0;
               busy_in           = 1'b1;
               wait_in           = 1'b0;
               rsp_send_valid_in = 1'b1;
               rsp_send_byte_in  = byte0_ff;
            end
         end
         saw_pkg::MODE_SERVICE: begin
            if (busy_ff && !wait_ff) begin
               if (!over_len && (next_idx != eff_len) && in_tx_ready_ff) begin
                  rsp_send_valid_in = 1'b1;
                  rsp_send_byte_in  = fetched_byte;
               end
               if (over_len) begin
                  wrapped = mod_status.rem;
               end else if (next_idx == eff_len) begin
                  wrapped = '0;
               end else begin
                  wrapped = next_idx;
               end
               send_index_in = ADDR_W'(wrapped);
               if (wrapped == '0) begin
                  busy_in = 1'b0;
                  if (!debug_mode_ff) begin
                     wait_in  = 1'b1;
                     busy_in  = 1'b1;
                     timer_in = reply_timeout_ff;
                  end
                  rx = 1'b0;
               end
            end
            if (busy_in && wait_in) begin
               if (timer_in != '0) begin
                  if (rx) begin
                     if (in_rx_byte_ff == ack_byte_ff) begin
                        busy_in      = 1'b0;
                        wait_in      = 1'b0;
                        rsp_event_in = saw_pkg::EV_ACK;
                     end else begin
                        wait_in           = 1'b0;
                        rsp_send_valid_in = 1'b1;
                        rsp_send_byte_in  = byte0_ff;
                        rsp_event_in      = saw_pkg::EV_RESEND;
                     end
                  end
               end else begin
                  busy_in      = 1'b0;
                  wait_in      = 1'b0;
                  rsp_event_in = saw_pkg::EV_TIMEOUT;
               end
            end
         end
         saw_pkg::MODE_TICK: begin
            if (timer_ff != '0) begin
               timer_in = timer_ff - TIMER_W'(1);
            end
         end
         default: ;
      endcase
   end

   // Store port: the write comes from a retiring load; the read fetches the
   // byte that the next service beat would send, from the index as it stands
   // after the retiring beat.
   assign wr_en   = advance && (in_mode_ff == saw_pkg::MODE_LOAD)
                    && (int'(in_load_index_ff) < saw_pkg::BUFFER_DEPTH);
   assign wr_addr = ADDR_W'(in_load_index_ff);
   assign rd_addr = (advance ? send_index_in : send_index_ff) + ADDR_W'(1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= in_load_byte_ff;
      end
      if (req_take) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == '0)) begin
         byte0_ff <= in_load_byte_ff;
      end
      if (req_take) begin
         fwd_hit_ff  <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= in_load_byte_ff;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (req_take) begin
         in_mode_ff       <= req_mode;
         in_load_index_ff <= req_load_index;
         in_load_byte_ff  <= req_load_byte;
         in_tx_ready_ff   <= req_tx_ready;
         in_rx_present_ff <= req_rx_present;
         in_rx_byte_ff    <= req_rx_byte;
      end
   end

   // Sender state and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         send_index_ff <= '0;
         busy_ff       <= 1'b0;
         wait_ff       <= 1'b0;
         timer_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (advance) begin
            send_index_ff <= send_index_in;
            busy_ff       <= busy_in;
            wait_ff       <= wait_in;
            timer_ff      <= timer_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
      if (advance) begin
         rsp_send_valid_ff <= rsp_send_valid_in;
         rsp_send_byte_ff  <= rsp_send_byte_in;
         rsp_event_ff      <= rsp_event_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_send_valid     = rsp_send_valid_ff;
   assign rsp_send_byte      = rsp_send_byte_ff;
   assign rsp_event_res      = rsp_event_ff;
   assign rsp_busy_res       = busy_ff;
   assign rsp_awaiting_reply = wait_ff;

   // Waiting for a reply is only possible while the packet is still busy.
   a_wait_implies_busy: assert property (@(posedge clock) disable iff (reset)
      wait_ff |-> busy_ff)
      else $error("wait flag set without busy flag");

   // No request beat may be taken while the modulo unit is reducing the index.
   a_no_take_during_mod: assert property (@(posedge clock) disable iff (reset)
      mod_status.busy |-> !req_ready)
      else $error("request taken while modulo unit busy");

   // An acknowledge or a timeout always leaves the sender idle.
   a_end_event_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_event_ff == saw_pkg::EV_ACK)
                        || (rsp_event_ff == saw_pkg::EV_TIMEOUT)))
      |-> (!busy_ff && !wait_ff))
      else $error("packet end event with sender still busy");

   // A resend always hands byte 0 to the transmitter.
   a_resend_sends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_event_ff == saw_pkg::EV_RESEND)) |-> rsp_send_valid_ff)
      else $error("resend event without a byte sent");

   // The sender index stays inside the packet once a service beat retires.
   a_index_in_len: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_mode_ff == saw_pkg::MODE_SERVICE)) |=> !over_len)
      else $error("send index beyond packet length after service");

endmodule
